### rtl/oicf_pkg.sv
// ----------------------------------------------------------------------------
// oicf_pkg
// Shared types, constants and helpers for the occupancy isolated-cell filter.
// ----------------------------------------------------------------------------
package oicf_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int DIM_W   = 11;                       // row/col count registers
   localparam int MINN_W  = 4;                        // min_neighbors register
   localparam int LEVEL_W = 11;                       // Q10 traversability
   localparam int CODE_W  = 2;
   localparam int CNT_W   = 4;                        // neighbor count, 0..8

   localparam int COL_W   = $clog2(MAX_COLS);         // column index
   localparam int COLC_W  = $clog2(MAX_COLS + 1);     // column count
   localparam int ROW_W   = $clog2(MAX_ROWS);         // output row index
   localparam int ROWC_W  = $clog2(MAX_ROWS + 1);     // row count
   localparam int INROW_W = $clog2(MAX_ROWS + 3);     // input row index, runs past end on drain

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NEIGHBORS = 2'd2;

   localparam logic CMD_CELL  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [LEVEL_W-1:0] LEVEL_ONE      = 11'd1024;
   localparam logic [LEVEL_W-1:0] LEVEL_HALF     = 11'd512;
   localparam logic [LEVEL_W-1:0] LEVEL_PROMOTED = 11'd614;

   localparam logic [DIM_W-1:0] ROW_COUNT_RESET = 11'd1024;
   localparam logic [DIM_W-1:0] COL_COUNT_RESET = 11'd1024;

   typedef enum logic [CODE_W-1:0] {
      CODE_UNKNOWN = 2'd0,
      CODE_FREE    = 2'd1,
      CODE_OCC     = 2'd2
   } occ_code_type;

   typedef struct packed {
      logic               command;
      logic [CODE_W-1:0]  occupancy_code;
      logic               trav_known;
      logic [LEVEL_W-1:0] trav_level;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]  occupancy_out;
      logic               trav_known_out;
      logic [LEVEL_W-1:0] trav_level_out;
      logic               cell_removed;
      logic               frame_last;
   } rsp_type;

   // one line-buffer entry: two rows of codes plus the middle row's level
   typedef struct packed {
      logic [CODE_W-1:0]  upper;
      logic [CODE_W-1:0]  middle;
      logic               known;
      logic [LEVEL_W-1:0] level;
   } line_word_type;

   localparam int LINE_W = $bits(line_word_type);

   // one window column: occupied bits (bit 0 = top row) and the middle-row cell
   typedef struct packed {
      logic [2:0]         occ;
      logic [CODE_W-1:0]  code;
      logic               known;
      logic [LEVEL_W-1:0] level;
   } column_type;

   function automatic logic [COLC_W-1:0] clamp_cols(input logic [DIM_W-1:0] v);
      logic [COLC_W-1:0] r;
      if (v == '0) begin
         r = COLC_W'(1);
      end else if (int'(v) > MAX_COLS) begin
         r = COLC_W'(MAX_COLS);
      end else begin
         r = COLC_W'(v);
      end
      return r;
   endfunction

   function automatic logic [ROWC_W-1:0] clamp_rows(input logic [DIM_W-1:0] v);
      logic [ROWC_W-1:0] r;
      if (v == '0) begin
         r = ROWC_W'(1);
      end else if (int'(v) > MAX_ROWS) begin
         r = ROWC_W'(MAX_ROWS);
      end else begin
         r = ROWC_W'(v);
      end
      return r;
   endfunction

endpackage

### rtl/oicf_line_ram.sv
// ----------------------------------------------------------------------------
// oicf_line_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module oicf_line_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-before-write on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/oicf_window_cell.sv
// ----------------------------------------------------------------------------
// oicf_window_cell
// One column of the 3x3 window; takes its neighbor's column on every shift.
// ----------------------------------------------------------------------------
module oicf_window_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  oicf_pkg::column_type col_in,
   output oicf_pkg::column_type col_out
);

   oicf_pkg::column_type col_ff;
   oicf_pkg::column_type col_in_w;

   always_comb begin
      col_in_w = shift_en ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_out = col_ff;

endmodule

### rtl/occupancy_isolated_cell_filter_core.sv
// ----------------------------------------------------------------------------
// occupancy_isolated_cell_filter_core
// Removes isolated occupied cells from a raster-order occupancy grid stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries grid cells (command = cell) or flush ticks in raster order;
//   rsp_* returns one filtered cell per position, lagging the input by
//   col_count + 1 positions. Flush ticks after the last cell drain the tail;
//   frame_last marks the final cell of the frame.
//   csr_* writes row_count, col_count and min_neighbors; geometry is latched
//   at the first cell of a frame.
// Timing:
//   One beat per cycle sustained while rsp_stall is low. A beat that yields a
//   result is registered into the cell stage as it is accepted (line RAM read
//   at the accept edge), then the window/count stage loads the output register
//   that drives rsp_valid. The rate is set by the line RAM, which takes one read
//   and one write-back per cell each cycle.
// Reset:
//   Synchronous; clears control, window and registers. Line RAM contents are
//   not cleared; stale entries only fall outside the grid and are masked.
// Stall:
//   rsp_stall holds the output register; the cell stage then holds and
//   req_stall rises, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module occupancy_isolated_cell_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  oicf_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output oicf_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_write_en,
   input  logic [oicf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [oicf_pkg::DIM_W-1:0]           csr_wdata
);

   typedef struct packed {
      logic [oicf_pkg::CODE_W-1:0]  code;
      logic                         known;
      logic [oicf_pkg::LEVEL_W-1:0] level;
      logic [oicf_pkg::COL_W-1:0]   addr;
      logic                         has_result;
      logic                         col_first;
      logic                         col_last;
      logic                         row_first;
      logic                         row_last;
      logic                         last;
   } stage_type;

   // configuration
   logic [oicf_pkg::DIM_W-1:0]  row_count_ff;
   logic [oicf_pkg::DIM_W-1:0]  col_count_ff;
   logic [oicf_pkg::MINN_W-1:0] min_nb_ff;

   // frame control
   logic                          frame_active_ff, frame_active_in;
   logic [oicf_pkg::ROWC_W-1:0]   frame_rows_ff, frame_rows_in;
   logic [oicf_pkg::COLC_W-1:0]   frame_cols_ff, frame_cols_in;
   logic [oicf_pkg::INROW_W-1:0]  in_row_ff, in_row_in;
   logic [oicf_pkg::COL_W-1:0]    in_col_ff, in_col_in;
   logic [oicf_pkg::ROW_W-1:0]    out_row_ff, out_row_in;
   logic [oicf_pkg::COL_W-1:0]    out_col_ff, out_col_in;

   // cell stage
   logic                          s1_valid_ff, s1_valid_in;
   stage_type                     s1_ff, s1_in;
   logic                          fwd_sel_ff, fwd_sel_in;
   oicf_pkg::line_word_type       fwd_word_ff;
   logic                          s1_fire;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   oicf_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   // accept-side decode
   logic                          accept, starting, draining, process;
   logic [oicf_pkg::ROWC_W-1:0]   eff_rows;
   logic [oicf_pkg::COLC_W-1:0]   eff_cols;
   logic [oicf_pkg::INROW_W-1:0]  eff_in_row;
   logic [oicf_pkg::COL_W-1:0]    eff_in_col;
   logic [oicf_pkg::ROW_W-1:0]    eff_out_row;
   logic [oicf_pkg::COL_W-1:0]    eff_out_col;
   logic [oicf_pkg::COLC_W-1:0]   in_col_p1, out_col_p1;
   logic [oicf_pkg::ROWC_W-1:0]   out_row_p1;
   logic                          col_wrap, has_result, last;
   logic [oicf_pkg::CODE_W-1:0]   code_s;
   logic                          known_s;
   logic [oicf_pkg::LEVEL_W-1:0]  level_s;

   // line RAM and window
   logic [oicf_pkg::LINE_W-1:0]   ram_q;
   oicf_pkg::line_word_type       rd_word, wr_word;
   oicf_pkg::column_type          new_col, col_b, col_a;
   logic [2:0]                    row_mask, m_a, m_b, m_n;
   logic [oicf_pkg::CNT_W-1:0]    nb_count;
   logic                          removed;
   logic [oicf_pkg::LEVEL_W-1:0]  ol;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= oicf_pkg::ROW_COUNT_RESET;
         col_count_ff <= oicf_pkg::COL_COUNT_RESET;
         min_nb_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            oicf_pkg::CSR_ROW_COUNT:     row_count_ff <= csr_wdata;
            oicf_pkg::CSR_COL_COUNT:     col_count_ff <= csr_wdata;
            oicf_pkg::CSR_MIN_NEIGHBORS: min_nb_ff    <= csr_wdata[oicf_pkg::MINN_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------ accept and frame
   assign s1_fire   = s1_valid_ff && (!s1_ff.has_result || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;

   always_comb begin
      accept      = req_valid && !req_stall;
      starting    = !frame_active_ff;
      eff_rows    = starting ? oicf_pkg::clamp_rows(row_count_ff) : frame_rows_ff;
      eff_cols    = starting ? oicf_pkg::clamp_cols(col_count_ff) : frame_cols_ff;
      eff_in_row  = starting ? '0 : in_row_ff;
      eff_in_col  = starting ? '0 : in_col_ff;
      eff_out_row = starting ? '0 : out_row_ff;
      eff_out_col = starting ? '0 : out_col_ff;

      draining = eff_in_row >= oicf_pkg::INROW_W'(eff_rows);
      // a flush counts only once the whole frame is in; a fresh frame never drains
      process  = accept && !(req_data.command == oicf_pkg::CMD_FLUSH && !draining);

      case (req_data.occupancy_code)
         oicf_pkg::CODE_FREE,
         oicf_pkg::CODE_OCC: code_s = req_data.occupancy_code;
         default:            code_s = oicf_pkg::CODE_UNKNOWN;
      endcase
      known_s = req_data.trav_known;
      level_s = (req_data.trav_level > oicf_pkg::LEVEL_ONE) ? oicf_pkg::LEVEL_ONE
                                                            : req_data.trav_level;
      if (draining) begin
         code_s  = oicf_pkg::CODE_UNKNOWN;
         known_s = 1'b0;
         level_s = '0;
      end

      in_col_p1  = oicf_pkg::COLC_W'(eff_in_col) + oicf_pkg::COLC_W'(1);
      col_wrap   = in_col_p1 >= eff_cols;
      // lag of col_count + 1 positions, without forming row * cols
      has_result = (eff_in_row >= oicf_pkg::INROW_W'(2)) ||
                   (eff_in_row == oicf_pkg::INROW_W'(1) && eff_in_col != '0);

      out_col_p1 = oicf_pkg::COLC_W'(eff_out_col) + oicf_pkg::COLC_W'(1);
      out_row_p1 = oicf_pkg::ROWC_W'(eff_out_row) + oicf_pkg::ROWC_W'(1);
      last       = (out_row_p1 == eff_rows) && (out_col_p1 == eff_cols);

      frame_active_in = frame_active_ff;
      frame_rows_in   = frame_rows_ff;
      frame_cols_in   = frame_cols_ff;
      in_row_in       = in_row_ff;
      in_col_in       = in_col_ff;
      out_row_in      = out_row_ff;
      out_col_in      = out_col_ff;

      if (process) begin
         frame_active_in = 1'b1;
         frame_rows_in   = eff_rows;
         frame_cols_in   = eff_cols;
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = eff_in_row + oicf_pkg::INROW_W'(1);
         end else begin
            in_col_in = in_col_p1[oicf_pkg::COL_W-1:0];
            in_row_in = eff_in_row;
         end
         out_row_in = eff_out_row;
         out_col_in = eff_out_col;
         if (has_result) begin
            if (last) begin
               frame_active_in = 1'b0;
               in_row_in       = '0;
               in_col_in       = '0;
               out_row_in      = '0;
               out_col_in      = '0;
            end else if (out_col_p1 >= eff_cols) begin
               out_col_in = '0;
               out_row_in = out_row_p1[oicf_pkg::ROW_W-1:0];
            end else begin
               out_col_in = out_col_p1[oicf_pkg::COL_W-1:0];
            end
         end
      end

      s1_in.code       = code_s;
      s1_in.known      = known_s;
      s1_in.level      = level_s;
      s1_in.addr       = eff_in_col;
      s1_in.has_result = has_result;
      s1_in.col_first  = eff_out_col == '0;
      s1_in.col_last   = out_col_p1 >= eff_cols;
      s1_in.row_first  = eff_out_row == '0;
      s1_in.row_last   = out_row_p1 >= eff_rows;
      s1_in.last       = last;

      if (process) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      // one-column frames read the entry being written back this cycle
      fwd_sel_in = process ? (s1_fire && s1_ff.addr == eff_in_col) : fwd_sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_active_ff <= 1'b0;
         frame_rows_ff   <= oicf_pkg::ROWC_W'(1);
         frame_cols_ff   <= oicf_pkg::COLC_W'(1);
         in_row_ff       <= '0;
         in_col_ff       <= '0;
         out_row_ff      <= '0;
         out_col_ff      <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_sel_ff      <= 1'b0;
      end else begin
         frame_active_ff <= frame_active_in;
         frame_rows_ff   <= frame_rows_in;
         frame_cols_ff   <= frame_cols_in;
         in_row_ff       <= in_row_in;
         in_col_ff       <= in_col_in;
         out_row_ff      <= out_row_in;
         out_col_ff      <= out_col_in;
         s1_valid_ff     <= s1_valid_in;
         fwd_sel_ff      <= fwd_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         s1_ff       <= s1_in;
         fwd_word_ff <= wr_word;
      end
   end

   // ------------------------------------------------------------ line RAM
   oicf_line_ram #(
      .WIDTH (oicf_pkg::LINE_W),
      .DEPTH (oicf_pkg::MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.addr),
      .wr_data (wr_word),
      .rd_en   (process),
      .rd_addr (eff_in_col),
      .rd_data (ram_q)
   );

   // ---------------------------------------------------------- cell stage
   always_comb begin
      rd_word = fwd_sel_ff ? fwd_word_ff : oicf_pkg::line_word_type'(ram_q);

      wr_word.upper  = rd_word.middle;
      wr_word.middle = s1_ff.code;
      wr_word.known  = s1_ff.known;
      wr_word.level  = s1_ff.level;

      new_col.occ   = {s1_ff.code     == oicf_pkg::CODE_OCC,
                       rd_word.middle == oicf_pkg::CODE_OCC,
                       rd_word.upper  == oicf_pkg::CODE_OCC};
      new_col.code  = rd_word.middle;
      new_col.known = rd_word.known;
      new_col.level = rd_word.level;
   end

   // window after this beat: col_a | col_b (center) | new_col
   oicf_window_cell u_cell_b (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_fire),
      .col_in   (new_col),
      .col_out  (col_b)
   );

   oicf_window_cell u_cell_a (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_fire),
      .col_in   (col_b),
      .col_out  (col_a)
   );

   always_comb begin
      row_mask = {!s1_ff.row_last, 1'b1, !s1_ff.row_first};
      m_a      = col_a.occ   & row_mask & {3{!s1_ff.col_first}};
      m_b      = col_b.occ   & row_mask & 3'b101;
      m_n      = new_col.occ & row_mask & {3{!s1_ff.col_last}};
      nb_count = oicf_pkg::CNT_W'($countones({m_a, m_b, m_n}));

      ol      = col_b.known ? col_b.level : '0;
      removed = (col_b.code == oicf_pkg::CODE_OCC) && (min_nb_ff != '0) &&
                (oicf_pkg::MINN_W'(nb_count) < min_nb_ff);

      rsp_data_in.occupancy_out  = removed ? oicf_pkg::CODE_FREE : col_b.code;
      rsp_data_in.trav_known_out = col_b.known;
      rsp_data_in.trav_level_out = (removed && col_b.known && ol < oicf_pkg::LEVEL_HALF)
                                   ? oicf_pkg::LEVEL_PROMOTED : ol;
      rsp_data_in.cell_removed   = removed;
      rsp_data_in.frame_last     = s1_ff.last;

      if (s1_fire && s1_ff.has_result) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.has_result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### tb/sv/occupancy_isolated_cell_filter_core_test.sv
// ----------------------------------------------------------------------------
// occupancy_isolated_cell_filter_core_test
// Self-checking bench for the isolated occupied cell filter. A queue of
// cell and flush beats feeds a clocked driver with random idle bursts. A
// local 3x3 window predictor turns the accepted beats into the filtered cells
// they should produce. A clocked monitor under random stall bursts checks every
// result beat in order against those cells.
// ----------------------------------------------------------------------------
module occupancy_isolated_cell_filter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 1020;
   localparam int QUIET_FROM     = 860;
   localparam int REPORT_MAX     = 10;
   localparam logic [oicf_pkg::CODE_W-1:0] CODE_RESERVED = 2'd3;

   logic                           clock;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_stall;
   oicf_pkg::req_type              req_data     = '0;
   logic                           rsp_valid;
   logic                           rsp_stall    = 1'b0;
   oicf_pkg::rsp_type              rsp_data;
   logic                           csr_write_en = 1'b0;
   logic [oicf_pkg::CSR_IDX_W-1:0] csr_index    = oicf_pkg::CSR_ROW_COUNT;
   logic [oicf_pkg::DIM_W-1:0]     csr_wdata    = '0;
   logic                           moving;

   occupancy_isolated_cell_filter_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   assign moving = (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en;

   // stimulus and expected results
   oicf_pkg::req_type cell_q[$];
   oicf_pkg::rsp_type filtered_q[$];

   // register copies
   logic [oicf_pkg::DIM_W-1:0]  cfg_rows = oicf_pkg::ROW_COUNT_RESET;
   logic [oicf_pkg::DIM_W-1:0]  cfg_cols = oicf_pkg::COL_COUNT_RESET;
   logic [oicf_pkg::MINN_W-1:0] cfg_min  = '0;

   // window predictor state
   logic [oicf_pkg::CODE_W-1:0]  line_upper  [oicf_pkg::MAX_COLS] = '{default: '0};
   logic [oicf_pkg::CODE_W-1:0]  line_middle [oicf_pkg::MAX_COLS] = '{default: '0};
   logic [oicf_pkg::LEVEL_W-1:0] line_level  [oicf_pkg::MAX_COLS] = '{default: '0};
   logic                         line_known  [oicf_pkg::MAX_COLS] = '{default: 1'b0};
   logic [8:0]                   win_occ = '0;
   logic [oicf_pkg::CODE_W-1:0]  center_code  [2] = '{default: '0};
   logic                         center_known [2] = '{default: 1'b0};
   logic [oicf_pkg::LEVEL_W-1:0] center_level [2] = '{default: '0};
   bit                           frame_open = 1'b0;
   int                           frame_rows = 1, frame_cols = 1;
   int                           in_row = 0, in_col = 0, out_row = 0, out_col = 0;

   int  beats_queued = 0, beats_sent = 0, cells_checked = 0;
   int  frames_done = 0, cells_removed = 0, errors = 0;
   int  gap_left = 0, stall_left = 0;
   bit  quiet = 1'b0;
   oicf_pkg::rsp_type want;

   function automatic int clamp_dim(logic [oicf_pkg::DIM_W-1:0] v, int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic void filter_step(oicf_pkg::req_type beat);
      logic [oicf_pkg::CODE_W-1:0]  code, top, mid;
      logic                         known;
      logic [oicf_pkg::LEVEL_W-1:0] level;
      bit                           draining;
      int                           pos, nbrs;
      oicf_pkg::rsp_type            res;

      if (!frame_open) begin
         if (beat.command == oicf_pkg::CMD_FLUSH) return;
         frame_rows = clamp_dim(cfg_rows, oicf_pkg::MAX_ROWS);
         frame_cols = clamp_dim(cfg_cols, oicf_pkg::MAX_COLS);
         frame_open = 1'b1;
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end
      draining = in_row >= frame_rows;
      if (beat.command == oicf_pkg::CMD_FLUSH && !draining) return;

      code  = beat.occupancy_code;
      known = beat.trav_known;
      level = beat.trav_level;
      if (code > oicf_pkg::CODE_OCC) code = oicf_pkg::CODE_UNKNOWN;
      if (level > oicf_pkg::LEVEL_ONE) level = oicf_pkg::LEVEL_ONE;
      if (draining) begin
         code = oicf_pkg::CODE_UNKNOWN;
         known = 1'b0;
         level = '0;
      end

      pos = in_row * frame_cols + in_col;
      top = line_upper[in_col];
      mid = line_middle[in_col];
      line_upper[in_col]  = mid;
      line_middle[in_col] = code;
      center_code[0]  = center_code[1];
      center_known[0] = center_known[1];
      center_level[0] = center_level[1];
      center_code[1]  = mid;
      center_known[1] = line_known[in_col];
      center_level[1] = line_level[in_col];
      line_level[in_col] = level;
      line_known[in_col] = known;
      // bit 0 of each window column is the top row
      win_occ = {code == oicf_pkg::CODE_OCC, mid == oicf_pkg::CODE_OCC,
                 top == oicf_pkg::CODE_OCC, win_occ[8:3]};
      in_col++;
      if (in_col >= frame_cols) begin
         in_col = 0;
         in_row++;
      end
      if (pos < frame_cols + 1) return;

      nbrs = 0;
      for (int wc = 0; wc < 3; wc++) begin
         for (int wr = 0; wr < 3; wr++) begin
            if ((wc == 0 && out_col == 0) || (wc == 2 && out_col + 1 >= frame_cols) ||
                (wc == 1 && wr == 1) || (wr == 0 && out_row == 0) ||
                (wr == 2 && out_row + 1 >= frame_rows)) continue;
            nbrs += win_occ[wc * 3 + wr];
         end
      end

      res.occupancy_out  = center_code[0];
      res.trav_known_out = center_known[0];
      res.trav_level_out = center_known[0] ? center_level[0] : '0;
      res.cell_removed   = 1'b0;
      if (center_code[0] == oicf_pkg::CODE_OCC && cfg_min != '0 && nbrs < int'(cfg_min)) begin
         res.occupancy_out = oicf_pkg::CODE_FREE;
         res.cell_removed  = 1'b1;
         if (center_known[0] && res.trav_level_out < oicf_pkg::LEVEL_HALF)
            res.trav_level_out = oicf_pkg::LEVEL_PROMOTED;
      end
      res.frame_last = (out_row + 1 == frame_rows) && (out_col + 1 == frame_cols);
      filtered_q = {filtered_q, res};

      if (res.frame_last) begin
         frame_open = 1'b0;
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= frame_cols) begin
            out_col = 0;
            out_row++;
         end
      end
   endfunction

   function automatic void push_beat(logic cmd, logic [oicf_pkg::CODE_W-1:0] code,
                                     logic known, logic [oicf_pkg::LEVEL_W-1:0] level);
      oicf_pkg::req_type b;
      b.command        = cmd;
      b.occupancy_code = code;
      b.trav_known     = known;
      b.trav_level     = level;
      cell_q = {cell_q, b};
      beats_queued++;
   endfunction

   function automatic void push_random(logic cmd, int density);
      logic [oicf_pkg::CODE_W-1:0]  code;
      logic [oicf_pkg::LEVEL_W-1:0] level;
      if ($urandom_range(0, 99) < density) begin
         code = oicf_pkg::CODE_OCC;
      end else begin
         case ($urandom_range(0, 2))
            0:       code = oicf_pkg::CODE_UNKNOWN;
            1:       code = oicf_pkg::CODE_FREE;
            default: code = CODE_RESERVED;
         endcase
      end
      // weight levels toward the promotion threshold
      case ($urandom_range(0, 9))
         0, 1, 2, 3: level = oicf_pkg::LEVEL_W'($urandom_range(0, 511));
         4, 5:       level = oicf_pkg::LEVEL_W'($urandom_range(480, 640));
         6, 7, 8:    level = oicf_pkg::LEVEL_W'($urandom_range(0, 1024));
         default:    level = oicf_pkg::LEVEL_W'($urandom_range(1025, 2047));
      endcase
      push_beat(cmd, code, 1'($urandom_range(0, 1)), level);
   endfunction

   // one whole frame at the current geometry, then its drain ticks
   function automatic void queue_frame(int density, bit noisy);
      int rows, cols;
      rows = clamp_dim(cfg_rows, oicf_pkg::MAX_ROWS);
      cols = clamp_dim(cfg_cols, oicf_pkg::MAX_COLS);
      for (int i = 0; i < rows * cols; i++) begin
         if (noisy && $urandom_range(0, 19) == 0) push_random(oicf_pkg::CMD_FLUSH, density);
         push_random(oicf_pkg::CMD_CELL, density);
      end
      for (int i = 0; i <= cols; i++)
         push_random((noisy && $urandom_range(0, 5) == 0) ? oicf_pkg::CMD_CELL
                                                          : oicf_pkg::CMD_FLUSH, density);
      if (noisy && $urandom_range(0, 2) == 0) push_random(oicf_pkg::CMD_FLUSH, density);
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (cell_q.size() != 0 || req_valid || filtered_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(int rows, int cols, int minn);
      wait_idle();
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= oicf_pkg::CSR_ROW_COUNT;
      csr_wdata    <= oicf_pkg::DIM_W'(rows);
      cfg_rows      = oicf_pkg::DIM_W'(rows);
      @(posedge clock);
      csr_index    <= oicf_pkg::CSR_COL_COUNT;
      csr_wdata    <= oicf_pkg::DIM_W'(cols);
      cfg_cols      = oicf_pkg::DIM_W'(cols);
      @(posedge clock);
      csr_index    <= oicf_pkg::CSR_MIN_NEIGHBORS;
      csr_wdata    <= oicf_pkg::DIM_W'(minn);
      cfg_min       = oicf_pkg::MINN_W'(minn);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // driver: holds a stalled beat, otherwise idles in bursts or sends the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_step(req_data);
            beats_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the beat
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (cell_q.size() != 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else begin
               req_data  <= cell_q.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: checks each result beat, stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_MAX)
                  $display("extra result: occ %0d known %0d level %0d rm %0d last %0d",
                           rsp_data.occupancy_out, rsp_data.trav_known_out,
                           rsp_data.trav_level_out, rsp_data.cell_removed, rsp_data.frame_last);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_data !== want) begin
                  errors++;
                  if (errors <= REPORT_MAX) begin
                     $display("cell %0d exp occ %0d known %0d level %0d rm %0d last %0d",
                              cells_checked, want.occupancy_out, want.trav_known_out,
                              want.trav_level_out, want.cell_removed, want.frame_last);
                     $display("cell %0d got occ %0d known %0d level %0d rm %0d last %0d",
                              cells_checked, rsp_data.occupancy_out, rsp_data.trav_known_out,
                              rsp_data.trav_level_out, rsp_data.cell_removed,
                              rsp_data.frame_last);
                  end
               end
               if (want.frame_last) frames_done++;
               if (want.cell_removed) cells_removed++;
               cells_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || moving) stuck = 0;
         else stuck++;
      end
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int base, rows, cols, minn;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // 3x3: isolated corners, reserved code, levels past 1.0, early and idle flushes,
      // a cell beat in the drain
      set_config(3, 3, 2);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_OCC,     1'b1, 11'd100);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd100);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_FREE,    1'b1, 11'd2047);
      push_beat(oicf_pkg::CMD_CELL,  CODE_RESERVED,          1'b1, 11'd1500);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_FREE,    1'b0, 11'd0);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_OCC,     1'b1, 11'd5);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b0, 11'd300);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_UNKNOWN, 1'b1, 11'd700);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd511);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_FREE,    1'b1, oicf_pkg::LEVEL_HALF);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, oicf_pkg::LEVEL_ONE);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd2047);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_FREE,    1'b1, 11'd9);

      // 1x1 frame: the first drain tick has nothing to show yet
      set_config(1, 1, 8);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd0);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);
      push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);

      // minimum above eight demotes every occupied cell
      set_config(2, 2, 15);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd511);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, oicf_pkg::LEVEL_HALF);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b0, 11'd100);
      push_beat(oicf_pkg::CMD_CELL,  oicf_pkg::CODE_OCC,     1'b1, 11'd0);
      repeat (3) push_beat(oicf_pkg::CMD_FLUSH, oicf_pkg::CODE_UNKNOWN, 1'b0, 11'd0);

      base = beats_queued;
      while (beats_queued - base < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       rows = 0;
            1:       rows = $urandom_range(7, 16);
            default: rows = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 9))
            0:       cols = 0;
            1:       cols = $urandom_range(11, 24);
            default: cols = $urandom_range(1, 10);
         endcase
         case ($urandom_range(0, 7))
            0:       minn = 0;
            1:       minn = $urandom_range(9, 15);
            default: minn = $urandom_range(1, 8);
         endcase
         set_config(rows, cols, minn);
         quiet = (beats_queued - base) >= QUIET_FROM;
         repeat ($urandom_range(1, 2))
            queue_frame($urandom_range(15, 90), $urandom_range(0, 3) != 0);
      end

      wait_idle();
      $display("%0d beats sent, %0d filtered cells checked over %0d frames, %0d cells removed",
               beats_sent, cells_checked, frames_done, cells_removed);
      $display("geometry 1x1 up to 16x24, minimum 0..15, flush corners, random idle and stall");
      if (errors == 0 && filtered_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d errors, %0d results missing", errors, filtered_q.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule
